@@ src/accel_tilt_rotation_matrix_assert.svh @@
// Assertion macros for the tilt rotation matrix block.
`ifndef ACCEL_TILT_ROTATION_MATRIX_ASSERT_SVH
`define ACCEL_TILT_ROTATION_MATRIX_ASSERT_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define ATRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ATRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATRM_ASSERT(lbl, prop, msg)
`define ATRM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/atrm_pkg.sv @@
package atrm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int FIELD_W         = 16;
  localparam int CODE_W          = 2;
  localparam int LANES           = 8;

  localparam logic [CODE_W-1:0] CASE_NORMAL = 2'd0;
  localparam logic [CODE_W-1:0] CASE_ZERO   = 2'd1;
  localparam logic [CODE_W-1:0] CASE_FLIP   = 2'd2;

  // Angle datapath: internal units of pi/2^19
  localparam int ANG_STEPS    = 18;
  localparam int ANG_NORM_BIT = 28;
  localparam int ANG_HALF_PI  = 262144;
  localparam int ANG_PI       = 524288;
  localparam int ANG_W        = 22;
  localparam int ANG_CL_W     = 20;
  localparam int CORD_W       = 34;
  localparam int IDX_W        = 5;
  localparam logic [FIELD_W-1:0] TILT_PI = 16'd32768;

  // atan(2^-i) in units of pi/2^19
  function automatic logic [17:0] atan_step(input logic [IDX_W-1:0] i);
    logic [17:0] t;
    unique case (i)
      5'd0:    t = 18'd131072;
      5'd1:    t = 18'd77376;
      5'd2:    t = 18'd40884;
      5'd3:    t = 18'd20753;
      5'd4:    t = 18'd10417;
      5'd5:    t = 18'd5213;
      5'd6:    t = 18'd2607;
      5'd7:    t = 18'd1304;
      5'd8:    t = 18'd652;
      5'd9:    t = 18'd326;
      5'd10:   t = 18'd163;
      5'd11:   t = 18'd81;
      5'd12:   t = 18'd41;
      5'd13:   t = 18'd20;
      5'd14:   t = 18'd10;
      5'd15:   t = 18'd5;
      5'd16:   t = 18'd3;
      5'd17:   t = 18'd1;
      default: t = 18'd0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic load;
    logic div_en;
    logic sqrt_en;
  } lane_ctl_t;

  typedef struct packed {
    logic               done;
    logic [FIELD_W-1:0] angle;
  } tilt_stat_t;

  typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_SQRT, BK_WAIT} back_state_t;
  typedef enum logic [1:0] {TL_IDLE, TL_NORM, TL_ROT, TL_DONE} tilt_state_t;

endpackage

@@ src/atrm_if.sv @@
interface atrm_in_if import atrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

interface atrm_out_if import atrm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] rot_r0c0;
  logic signed [FIELD_W-1:0] rot_r0c1;
  logic signed [FIELD_W-1:0] rot_r0c2;
  logic signed [FIELD_W-1:0] rot_r1c0;
  logic signed [FIELD_W-1:0] rot_r1c1;
  logic signed [FIELD_W-1:0] rot_r1c2;
  logic signed [FIELD_W-1:0] rot_r2c0;
  logic signed [FIELD_W-1:0] rot_r2c1;
  logic signed [FIELD_W-1:0] rot_r2c2;
  logic [FIELD_W-1:0]        tilt_angle;
  logic [CODE_W-1:0]         case_code;

  modport source (output valid, output rot_r0c0, output rot_r0c1, output rot_r0c2,
                  output rot_r1c0, output rot_r1c1, output rot_r1c2,
                  output rot_r2c0, output rot_r2c1, output rot_r2c2,
                  output tilt_angle, output case_code, input ready);
  modport sink (input valid, input rot_r0c0, input rot_r0c1, input rot_r0c2,
                input rot_r1c0, input rot_r1c1, input rot_r1c2,
                input rot_r2c0, input rot_r2c1, input rot_r2c2,
                input tilt_angle, input case_code, output ready);
endinterface

@@ src/atrm_front.sv @@
module atrm_front import atrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_x,
  input  logic signed [SAMPLE_BITS-1:0]   in_y,
  input  logic signed [SAMPLE_BITS-1:0]   in_z,
  output logic                            job_valid,
  input  logic                            job_ready,
  output logic [CODE_W-1:0]               job_code,
  output logic                            job_xn,
  output logic                            job_yn,
  output logic                            job_zn,
  output logic                            job_zp,
  output logic [SAMPLE_BITS-1:0]          job_ux,
  output logic signed [SAMPLE_BITS-1:0]   job_z,
  output logic [2*SAMPLE_BITS-1:0]        job_xx,
  output logic [2*SAMPLE_BITS-1:0]        job_yy,
  output logic [2*SAMPLE_BITS-1:0]        job_zz,
  output logic [2*SAMPLE_BITS-1:0]        job_s2,
  output logic [2*SAMPLE_BITS-1:0]        job_m2,
  output logic [4*SAMPLE_BITS-1:0]        job_wmr,
  output logic [4*SAMPLE_BITS-1:0]        job_pxy,
  output logic [4*SAMPLE_BITS-1:0]        job_pyz
);

  localparam int SB     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SB;
  localparam int HP_W   = 3 * SB;
  localparam int PR_W   = 4 * SB;
  localparam int REST_W = CODE_W + 4 + 2 * SB;
  localparam int SIDE_W = REST_W + 5 * SQ_W;
  localparam int ENT_W  = SIDE_W + 3 * PR_W;

  logic        adv;
  logic [4:0]  vld_r;

  // stage 1: sample
  logic signed [SB-1:0] x1_r, y1_r, z1_r;
  // stage 2: squares
  logic [SB-1:0]        ux1, uy1, uz1;
  logic signed [SB-1:0] x2_r, y2_r, z2_r;
  logic [SB-1:0]        ux2_r;
  logic [SQ_W-1:0]      xx2_r, yy2_r, zz2_r;
  // stage 3: sums and class
  logic [SQ_W-1:0]      s2_c, m2_c;
  logic [CODE_W-1:0]    code_c;
  logic [REST_W-1:0]    rest3_r;
  logic [SQ_W-1:0]      xx3_r, yy3_r, zz3_r, s23_r, m23_r;
  // stage 4: partial products
  logic [SIDE_W-1:0]    side4_r;
  logic [HP_W-1:0]      pm_lo4_r, pm_hi4_r, pxy_lo4_r, pxy_hi4_r, pyz_lo4_r, pyz_hi4_r;
  // stage 5: wide products
  logic [SIDE_W-1:0]    side5_r;
  logic [PR_W-1:0]      wmr5_r, pxy5_r, pyz5_r;

  // queue
  logic [ENT_W-1:0]     ent_r [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;
  logic                 push, pop;
  logic [ENT_W-1:0]     head;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign push     = adv && vld_r[4];
  assign pop      = job_valid && job_ready;

  assign ux1 = x1_r[SB-1] ? SB'(-x1_r) : SB'(x1_r);
  assign uy1 = y1_r[SB-1] ? SB'(-y1_r) : SB'(y1_r);
  assign uz1 = z1_r[SB-1] ? SB'(-z1_r) : SB'(z1_r);

  assign s2_c = xx2_r + zz2_r;
  assign m2_c = s2_c + yy2_r;

  always_comb begin
    if (m2_c == '0) begin
      code_c = CASE_ZERO;
    end else if (s2_c == '0) begin
      code_c = CASE_FLIP;
    end else begin
      code_c = CASE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= in_x;
      y1_r  <= in_y;
      z1_r  <= in_z;

      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      ux2_r <= ux1;
      xx2_r <= SQ_W'(ux1) * SQ_W'(ux1);
      yy2_r <= SQ_W'(uy1) * SQ_W'(uy1);
      zz2_r <= SQ_W'(uz1) * SQ_W'(uz1);

      rest3_r <= {code_c, x2_r[SB-1], y2_r[SB-1], z2_r[SB-1],
                  (!z2_r[SB-1] && (z2_r != '0)), ux2_r, z2_r};
      xx3_r   <= xx2_r;
      yy3_r   <= yy2_r;
      zz3_r   <= zz2_r;
      s23_r   <= s2_c;
      m23_r   <= m2_c;

      // split each wide product into two half-width multiplies
      side4_r   <= {rest3_r, xx3_r, yy3_r, zz3_r, s23_r, m23_r};
      pm_lo4_r  <= HP_W'(m23_r) * HP_W'(s23_r[SB-1:0]);
      pm_hi4_r  <= HP_W'(m23_r) * HP_W'(s23_r[SQ_W-1:SB]);
      pxy_lo4_r <= HP_W'(xx3_r) * HP_W'(yy3_r[SB-1:0]);
      pxy_hi4_r <= HP_W'(xx3_r) * HP_W'(yy3_r[SQ_W-1:SB]);
      pyz_lo4_r <= HP_W'(zz3_r) * HP_W'(yy3_r[SB-1:0]);
      pyz_hi4_r <= HP_W'(zz3_r) * HP_W'(yy3_r[SQ_W-1:SB]);

      side5_r <= side4_r;
      wmr5_r  <= PR_W'(pm_lo4_r) + (PR_W'(pm_hi4_r) << SB);
      pxy5_r  <= PR_W'(pxy_lo4_r) + (PR_W'(pxy_hi4_r) << SB);
      pyz5_r  <= PR_W'(pyz_lo4_r) + (PR_W'(pyz_hi4_r) << SB);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= {side5_r, wmr5_r, pxy5_r, pyz5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];
  assign {job_code, job_xn, job_yn, job_zn, job_zp, job_ux, job_z,
          job_xx, job_yy, job_zz, job_s2, job_m2, job_wmr, job_pxy, job_pyz} = head;

endmodule

@@ src/atrm_lane.sv @@
module atrm_lane import atrm_pkg::*; #(
  parameter int DW        = 4 * SAMPLE_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [DW-1:0]      num,
  input  logic [DW-1:0]      den,
  input  logic               neg,
  output logic [FIELD_W-1:0] value
);

  localparam int QW  = 2 * FRAC_BITS + 4;
  localparam int RW  = FRAC_BITS + 2;
  localparam int SRW = FRAC_BITS + 5;
  localparam int OW  = (FRAC_BITS + 2 > FIELD_W) ? FRAC_BITS + 2 : FIELD_W;

  logic [DW-1:0]  den_r, rem_r;
  logic [QW-1:0]  quo_r;
  logic [RW-1:0]  root_r;
  logic [SRW-1:0] srem_r;
  logic           neg_r;

  logic           ld_ge;
  logic [DW-1:0]  ld_rem;
  logic [DW:0]    dtry, ddif;
  logic           dbit;
  logic [SRW-1:0] spull, strial;
  logic           sbit;
  logic [RW:0]    rnd;
  logic [OW-1:0]  qe, sv;

  // restoring divide: quotient bits MSB first into quo_r
  assign ld_ge  = (num >= den);
  assign ld_rem = ld_ge ? (num - den) : num;
  assign dtry   = {rem_r, 1'b0};
  assign ddif   = dtry - {1'b0, den_r};
  assign dbit   = (dtry >= {1'b0, den_r});

  // digit-by-digit square root, two quotient bits per step
  assign spull  = {srem_r[SRW-3:0], quo_r[QW-1 -: 2]};
  assign strial = SRW'({root_r, 2'b01});
  assign sbit   = (spull >= strial);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      den_r  <= den;
      rem_r  <= ld_rem;
      quo_r  <= QW'(ld_ge);
      root_r <= '0;
      srem_r <= '0;
      neg_r  <= neg;
    end else if (ctl.div_en) begin
      rem_r <= dbit ? ddif[DW-1:0] : dtry[DW-1:0];
      quo_r <= {quo_r[QW-2:0], dbit};
    end else if (ctl.sqrt_en) begin
      srem_r <= sbit ? (spull - strial) : spull;
      root_r <= {root_r[RW-2:0], sbit};
      quo_r  <= {quo_r[QW-3:0], 2'b00};
    end
  end

  // drop the guard bit with round half up, then apply sign
  assign rnd   = {1'b0, root_r} + (RW + 1)'(1);
  assign qe    = OW'(rnd[RW:1]);
  assign sv    = neg_r ? (~qe + OW'(1)) : qe;
  assign value = sv[FIELD_W-1:0];

endmodule

@@ src/atrm_tilt.sv @@
module atrm_tilt import atrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [SAMPLE_BITS-1:0]        ux,
  input  logic signed [SAMPLE_BITS-1:0] z,
  output tilt_stat_t                    stat
);

  localparam int SB = SAMPLE_BITS;

  tilt_state_t st_r, st_nxt;

  logic signed [CORD_W-1:0] cx_r, cy_r, dx, dy;
  logic signed [ANG_W-1:0]  acc_r, tv, ang_c;
  logic [IDX_W-1:0]         idx_r;
  logic                     base_r;
  logic [SB-1:0]            zmag;
  logic [SB-1:0]            ld_cx, ld_cy;
  logic                     ld_zero;
  logic                     norm_go;
  logic [ANG_CL_W-1:0]      ang_cl, ang_rnd;

  // a negative z is turned by pi/2 first
  assign zmag    = SB'(-z);
  assign ld_cx   = z[SB-1] ? ux : SB'(z);
  assign ld_cy   = z[SB-1] ? zmag : ux;
  assign ld_zero = ((ld_cx | ld_cy) == '0);
  assign norm_go = ((cx_r | cy_r) >>> ANG_NORM_BIT) == '0;
  assign dx      = cy_r >>> idx_r;
  assign dy      = cx_r >>> idx_r;
  assign tv      = ANG_W'(atan_step(idx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TL_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (load) begin
      st_nxt = ld_zero ? TL_DONE : TL_NORM;
    end else begin
      unique case (st_r)
        TL_IDLE: st_nxt = TL_IDLE;
        TL_NORM: st_nxt = norm_go ? TL_NORM : TL_ROT;
        TL_ROT:  st_nxt = (idx_r == IDX_W'(ANG_STEPS - 1)) ? TL_DONE : TL_ROT;
        TL_DONE: st_nxt = TL_DONE;
        default: st_nxt = TL_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cx_r   <= CORD_W'(ld_cx);
      cy_r   <= CORD_W'(ld_cy);
      acc_r  <= '0;
      idx_r  <= '0;
      base_r <= z[SB-1];
    end else if (st_r == TL_NORM && norm_go) begin
      cx_r <= cx_r <<< 1;
      cy_r <= cy_r <<< 1;
    end else if (st_r == TL_ROT) begin
      if (!cy_r[CORD_W-1]) begin
        cx_r  <= cx_r + dx;
        cy_r  <= cy_r - dy;
        acc_r <= acc_r + tv;
      end else begin
        cx_r  <= cx_r - dx;
        cy_r  <= cy_r + dy;
        acc_r <= acc_r - tv;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // clamp to [0, pi], then round to pi/32768 units
  assign ang_c = acc_r + (base_r ? ANG_W'(ANG_HALF_PI) : ANG_W'(0));

  always_comb begin
    if (ang_c < 0) begin
      ang_cl = '0;
    end else if (ang_c > ANG_W'(ANG_PI)) begin
      ang_cl = ANG_CL_W'(ANG_PI);
    end else begin
      ang_cl = ang_c[ANG_CL_W-1:0];
    end
  end

  assign ang_rnd    = ang_cl + ANG_CL_W'(8);
  assign stat.done  = (st_r == TL_DONE);
  assign stat.angle = ang_rnd[ANG_CL_W-1:4];

endmodule

@@ src/atrm_back.sv @@
`include "accel_tilt_rotation_matrix_assert.svh"

module atrm_back import atrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  logic [CODE_W-1:0]             job_code,
  input  logic                          job_xn,
  input  logic                          job_yn,
  input  logic                          job_zn,
  input  logic                          job_zp,
  input  logic [SAMPLE_BITS-1:0]        job_ux,
  input  logic signed [SAMPLE_BITS-1:0] job_z,
  input  logic [2*SAMPLE_BITS-1:0]      job_xx,
  input  logic [2*SAMPLE_BITS-1:0]      job_yy,
  input  logic [2*SAMPLE_BITS-1:0]      job_zz,
  input  logic [2*SAMPLE_BITS-1:0]      job_s2,
  input  logic [2*SAMPLE_BITS-1:0]      job_m2,
  input  logic [4*SAMPLE_BITS-1:0]      job_wmr,
  input  logic [4*SAMPLE_BITS-1:0]      job_pxy,
  input  logic [4*SAMPLE_BITS-1:0]      job_pyz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FIELD_W-1:0]            out_rot [9],
  output logic [FIELD_W-1:0]            out_angle,
  output logic [CODE_W-1:0]             out_code
);

  localparam int DW         = 4 * SAMPLE_BITS;
  localparam int DIV_STEPS  = 2 * FRAC_BITS + 2;
  localparam int CW         = $clog2(DIV_STEPS + 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(DIV_STEPS - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(FRAC_BITS + 1);
  localparam int ONE_INT    = 1 << FRAC_BITS;
  localparam logic [FIELD_W-1:0] ONE_Q     = FIELD_W'(ONE_INT);
  localparam logic [FIELD_W-1:0] NEG_ONE_Q = FIELD_W'(-ONE_INT);

  back_state_t st_r, st_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CODE_W-1:0]  code_r;
  lane_ctl_t          ctl;
  logic               tilt_load;
  tilt_stat_t         tstat;
  logic               out_load;

  logic [DW-1:0]      lane_num [LANES];
  logic [DW-1:0]      lane_den [LANES];
  logic               lane_neg [LANES];
  logic [FIELD_W-1:0] lane_val [LANES];

  logic               ov_r;
  logic [FIELD_W-1:0] rot_r [9];
  logic [FIELD_W-1:0] ang_r;
  logic [CODE_W-1:0]  ocode_r;

  // lane k computes round(2^F * sqrt(num/den)) for one nonzero matrix entry
  assign lane_num[0] = DW'(job_zz);  assign lane_den[0] = DW'(job_s2);  assign lane_neg[0] = job_zp;
  assign lane_num[1] = job_pxy;      assign lane_den[1] = job_wmr;      assign lane_neg[1] = job_xn ^ job_yn;
  assign lane_num[2] = DW'(job_xx);  assign lane_den[2] = DW'(job_m2);  assign lane_neg[2] = job_xn;
  assign lane_num[3] = DW'(job_s2);  assign lane_den[3] = DW'(job_m2);  assign lane_neg[3] = 1'b1;
  assign lane_num[4] = DW'(job_yy);  assign lane_den[4] = DW'(job_m2);  assign lane_neg[4] = job_yn;
  assign lane_num[5] = DW'(job_xx);  assign lane_den[5] = DW'(job_s2);  assign lane_neg[5] = job_xn;
  assign lane_num[6] = job_pyz;      assign lane_den[6] = job_wmr;      assign lane_neg[6] = job_yn ^ job_zn;
  assign lane_num[7] = DW'(job_zz);  assign lane_den[7] = DW'(job_m2);  assign lane_neg[7] = job_zn;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    atrm_lane #(
      .DW        (DW),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .num   (lane_num[k]),
      .den   (lane_den[k]),
      .neg   (lane_neg[k]),
      .value (lane_val[k])
    );
  end

  atrm_tilt #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tilt (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (tilt_load),
    .ux    (job_ux),
    .z     (job_z),
    .stat  (tstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    job_ready   = 1'b0;
    ctl         = '0;
    tilt_load   = 1'b0;
    out_load    = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          ctl.load  = 1'b1;
          tilt_load = 1'b1;
          cnt_nxt   = '0;
          st_nxt    = BK_DIV;
        end
      end
      BK_DIV: begin
        ctl.div_en = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          st_nxt  = BK_SQRT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      BK_SQRT: begin
        ctl.sqrt_en = 1'b1;
        if (cnt_r == SQRT_LAST) begin
          cnt_nxt = '0;
          st_nxt  = BK_WAIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      BK_WAIT: begin
        if (tstat.done && (!ov_r || out_ready)) begin
          out_load = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      code_r <= job_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ocode_r <= code_r;
      case (code_r)
        CASE_ZERO: begin
          rot_r <= '{ONE_Q, '0, '0, '0, ONE_Q, '0, '0, '0, ONE_Q};
          ang_r <= '0;
        end
        CASE_FLIP: begin
          rot_r <= '{ONE_Q, '0, '0, '0, NEG_ONE_Q, '0, '0, '0, NEG_ONE_Q};
          ang_r <= TILT_PI;
        end
        default: begin
          rot_r <= '{lane_val[0], lane_val[1], lane_val[2],
                     '0,          lane_val[3], lane_val[4],
                     lane_val[5], lane_val[6], lane_val[7]};
          ang_r <= tstat.angle;
        end
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_rot   = rot_r;
  assign out_angle = ang_r;
  assign out_code  = ocode_r;

  `ATRM_ASSERT(a_take_starts_div, (job_valid && job_ready) |=> (st_r == BK_DIV), "job transfer did not start the divide")
  `ATRM_ASSERT(a_sqrt_then_wait, (st_r == BK_SQRT && cnt_r == SQRT_LAST) |=> (st_r == BK_WAIT), "square root overran its step count")
  `ATRM_ASSERT(a_out_from_wait, $rose(ov_r) |-> $past(st_r == BK_WAIT && tstat.done), "result loaded before the angle was done")
  `ATRM_ASSERT_ALWAYS(a_reset_clears_out, (!rst_n) |=> (!ov_r), "reset left a result pending")

endmodule

@@ src/accel_tilt_rotation_matrix.sv @@
// Accelerometer tilt to orientation matrix. Each transfer on in_ch carries one signed
// sample (x, y, z); each transfer on out_ch returns the 3x3 matrix in Q2.FRAC_BITS
// (masked to 16 bits), the inclination atan2(|x|, z) in units of pi/32768 and a
// case code: the zero vector gives the identity, a vector along y gives
// diag(1, -1, -1) with an angle of pi. A five-stage front end takes one sample per
// cycle while its queue has room, forms the squares, sums and wide products, and
// parks the job in a two-entry queue. The back end then runs eight entry lanes in
// parallel, each a restoring divider of 2*FRAC_BITS+2 steps followed by a square
// root of FRAC_BITS+2 steps, next to a CORDIC angle unit of up to 28 normalizing
// shifts plus 18 rotations. The lanes' divide and root steps set how long one
// sample occupies the back end; a small input whose angle needs all 28
// normalizing shifts holds it longer, until the angle unit is done. The result
// sits in an output register, so the back end starts on the next queued sample
// while a result waits to be taken. A sample passes through the five front-end
// stages and the queue before the back end takes it.
module accel_tilt_rotation_matrix import atrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  atrm_in_if.sink     in_ch,
  atrm_out_if.source  out_ch
);

  localparam int SB = SAMPLE_BITS;

  // front to back job
  logic                 job_valid, job_ready;
  logic [CODE_W-1:0]    job_code;
  logic                 job_xn, job_yn, job_zn, job_zp;
  logic [SB-1:0]        job_ux;
  logic signed [SB-1:0] job_z;
  logic [2*SB-1:0]      job_xx, job_yy, job_zz, job_s2, job_m2;
  logic [4*SB-1:0]      job_wmr, job_pxy, job_pyz;

  logic [FIELD_W-1:0]   rot [9];

  // classify, square and multiply; hold the job in the queue
  atrm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_x      (in_ch.sample_x),
    .in_y      (in_ch.sample_y),
    .in_z      (in_ch.sample_z),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_code  (job_code),
    .job_xn    (job_xn),
    .job_yn    (job_yn),
    .job_zn    (job_zn),
    .job_zp    (job_zp),
    .job_ux    (job_ux),
    .job_z     (job_z),
    .job_xx    (job_xx),
    .job_yy    (job_yy),
    .job_zz    (job_zz),
    .job_s2    (job_s2),
    .job_m2    (job_m2),
    .job_wmr   (job_wmr),
    .job_pxy   (job_pxy),
    .job_pyz   (job_pyz)
  );

  // divide, root and angle; drive the output register
  atrm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_code  (job_code),
    .job_xn    (job_xn),
    .job_yn    (job_yn),
    .job_zn    (job_zn),
    .job_zp    (job_zp),
    .job_ux    (job_ux),
    .job_z     (job_z),
    .job_xx    (job_xx),
    .job_yy    (job_yy),
    .job_zz    (job_zz),
    .job_s2    (job_s2),
    .job_m2    (job_m2),
    .job_wmr   (job_wmr),
    .job_pxy   (job_pxy),
    .job_pyz   (job_pyz),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rot   (rot),
    .out_angle (out_ch.tilt_angle),
    .out_code  (out_ch.case_code)
  );

  assign out_ch.rot_r0c0 = rot[0];
  assign out_ch.rot_r0c1 = rot[1];
  assign out_ch.rot_r0c2 = rot[2];
  assign out_ch.rot_r1c0 = rot[3];
  assign out_ch.rot_r1c1 = rot[4];
  assign out_ch.rot_r1c2 = rot[5];
  assign out_ch.rot_r2c0 = rot[6];
  assign out_ch.rot_r2c1 = rot[7];
  assign out_ch.rot_r2c2 = rot[8];

endmodule
